// ===== design/lrupr_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
// No dependencies; imported by every module of the block except lrupr_ram.
package lrupr_pkg;

  localparam int SLOT_OUT_W = 4;   // width of the slot result field
  localparam int OCC_W      = 5;   // width of the occupied result field
  localparam int TOTAL_W    = 32;  // width of the hit and fault totals
  localparam int CFG_W      = 5;   // width of the frame_count register
  localparam int CAP_W      = 8;   // compare width for capacity checks

  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 5'd16;

  // Result of the shared compare unit for one frame entry
  typedef struct packed {
    logic match;  // entry page equals the referenced page
    logic older;  // entry rank at or above the oldest rank seen so far
    logic age;    // entry must move one step toward least recent
  } cmp_res_t;

endpackage

// ===== design/lrupr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lrupr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lrupr_cmp.sv =====
// Shared compare unit: evaluates one frame entry per cycle for the sequencer.
// Depends on lrupr_pkg (cmp_res_t).
module lrupr_cmp import lrupr_pkg::*; #(
  parameter int PAGE_BITS = 16,
  parameter int RANK_W    = 4
) (
  input  logic [PAGE_BITS-1:0] entry_page,
  input  logic [RANK_W-1:0]    entry_rank,
  input  logic [PAGE_BITS-1:0] ref_page,
  input  logic [RANK_W-1:0]    best_rank,
  input  logic [RANK_W-1:0]    limit_rank,
  input  logic                 age_all,
  output cmp_res_t             res,
  output logic [RANK_W-1:0]    rank_inc
);

  always_comb begin
    res.match = (entry_page == ref_page);
    res.older = (entry_rank >= best_rank);
    res.age   = age_all || (entry_rank < limit_rank);
  end

  assign rank_inc = entry_rank + RANK_W'(1);

endmodule

// ===== design/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block: sequencer, counters, frame RAM.
// Depends on lrupr_pkg, lrupr_ram, lrupr_cmp.
//
//  channel   signals                                         direction
//  -------   ----------------------------------------------  ---------
//  request   start, page, start_string; busy                 in; busy out
//  result    done, hit, slot, evicted_valid, evicted_page,   out
//            occupied, fault_total, hit_total
//  config    cfg_we, cfg_data (frame_count)                  in
//
// A request runs a search pass over the frames filled at accept (after any
// start_string clear), a decide state, then a rank-aging RMW pass that on a
// fill also covers the new slot, all through the single RAM read port and the
// shared compare unit.
// Reset is synchronous; frames start empty and frame_count reads 16.
// busy is high from accept until done; done is a one-cycle strobe, never stalled.
module lru_page_replacement_top import lrupr_pkg::*; #(
  parameter int MAX_FRAME_SLOTS = 16,
  parameter int PAGE_BITS       = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 start_string,
  output logic                 done,
  output logic                 hit,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [OCC_W-1:0]     occupied,
  output logic [TOTAL_W-1:0]   fault_total,
  output logic [TOTAL_W-1:0]   hit_total
);

  localparam int IDX_W  = (MAX_FRAME_SLOTS > 1) ? $clog2(MAX_FRAME_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAME_SLOTS + 1);
  localparam int RANK_W = IDX_W;
  localparam int ENT_W  = PAGE_BITS + RANK_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_DECIDE, ST_UPDATE} state_t;

  state_t               state;
  logic [CFG_W-1:0]     frame_count;
  logic [CNT_W-1:0]     filled;
  logic [TOTAL_W-1:0]   faults;
  logic [TOTAL_W-1:0]   hits;
  logic [CNT_W-1:0]     issue;
  logic                 pend;
  logic [IDX_W-1:0]     pend_idx;
  logic [PAGE_BITS-1:0] page_reg;
  logic                 found;
  logic [IDX_W-1:0]     fslot;
  logic [RANK_W-1:0]    frank;
  logic [IDX_W-1:0]     oslot;
  logic [RANK_W-1:0]    orank;
  logic [PAGE_BITS-1:0] opage;
  logic [IDX_W-1:0]     tslot;
  logic [RANK_W-1:0]    tlimit;
  logic                 age_all;
  logic                 hit_r;
  logic                 evict_r;

  logic [ENT_W-1:0]     rdata;
  logic [ENT_W-1:0]     wdata;
  logic                 we;
  logic [PAGE_BITS-1:0] entry_page;
  logic [RANK_W-1:0]    entry_rank;
  logic [RANK_W-1:0]    rank_inc;
  cmp_res_t             cres;

  logic [CAP_W-1:0]     fc_ext;
  logic [CAP_W-1:0]     cap;
  logic                 full;
  logic                 more;

  assign busy = (state != ST_IDLE);

  assign entry_page = rdata[ENT_W-1:RANK_W];
  assign entry_rank = rdata[RANK_W-1:0];

  // capacity: zero counts as one, anything above the slot count saturates
  always_comb begin
    fc_ext = CAP_W'(frame_count);
    if (fc_ext == '0) begin
      cap = CAP_W'(1);
    end else if (fc_ext > CAP_W'(MAX_FRAME_SLOTS)) begin
      cap = CAP_W'(MAX_FRAME_SLOTS);
    end else begin
      cap = fc_ext;
    end
    full = (CAP_W'(filled) >= cap);
    more = (issue < filled);
  end

  // write-back during the aging pass
  always_comb begin
    we = (state == ST_UPDATE) && pend && ((pend_idx == tslot) || cres.age);
    if (pend_idx == tslot) begin
      wdata = {page_reg, {RANK_W{1'b0}}};
    end else begin
      wdata = {entry_page, rank_inc};
    end
  end

  lrupr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_FRAME_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (pend_idx),
    .wdata (wdata),
    .raddr (issue[IDX_W-1:0]),
    .rdata (rdata)
  );

  lrupr_cmp #(
    .PAGE_BITS (PAGE_BITS),
    .RANK_W    (RANK_W)
  ) u_cmp (
    .entry_page (entry_page),
    .entry_rank (entry_rank),
    .ref_page   (page_reg),
    .best_rank  (orank),
    .limit_rank (tlimit),
    .age_all    (age_all),
    .res        (cres),
    .rank_inc   (rank_inc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_count <= FRAME_COUNT_RESET;
      filled      <= '0;
      faults      <= '0;
      hits        <= '0;
      issue       <= '0;
      pend        <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            page_reg <= page;
            found    <= 1'b0;
            oslot    <= '0;
            orank    <= '0;
            issue    <= '0;
            pend     <= 1'b0;
            if (start_string) begin
              filled <= '0;
              faults <= '0;
              hits   <= '0;
            end
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          pend     <= more;
          pend_idx <= issue[IDX_W-1:0];
          if (more) begin
            issue <= issue + CNT_W'(1);
          end
          if (pend) begin
            // first match wins; the oldest is the last entry at the top rank
            if (cres.match && !found) begin
              found <= 1'b1;
              fslot <= pend_idx;
              frank <= entry_rank;
            end
            if (cres.older) begin
              oslot <= pend_idx;
              orank <= entry_rank;
              opage <= entry_page;
            end
          end
          if (!more && !pend) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          issue   <= '0;
          pend    <= 1'b0;
          hit_r   <= found;
          evict_r <= 1'b0;
          age_all <= 1'b0;
          if (found) begin
            hits   <= hits + TOTAL_W'(1);
            tslot  <= fslot;
            tlimit <= frank;
          end else begin
            faults <= faults + TOTAL_W'(1);
            if (full) begin
              tslot   <= oslot;
              tlimit  <= orank;
              evict_r <= 1'b1;
            end else begin
              // new page goes to the next free slot; every other page ages
              tslot   <= filled[IDX_W-1:0];
              tlimit  <= '0;
              age_all <= 1'b1;
              filled  <= filled + CNT_W'(1);
            end
          end
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          pend     <= more;
          pend_idx <= issue[IDX_W-1:0];
          done     <= !more && !pend;
          if (more) begin
            issue <= issue + CNT_W'(1);
          end
          if (!more && !pend) begin
            hit           <= hit_r;
            slot          <= SLOT_OUT_W'(tslot);
            evicted_valid <= evict_r;
            evicted_page  <= evict_r ? opage : '0;
            occupied      <= OCC_W'(filled);
            fault_total   <= faults;
            hit_total     <= hits;
            state         <= ST_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/lrupr_checker.sv =====
// Port-level checks for lru_page_replacement_top, attached by bind.
// Depends on lrupr_pkg, which it imports.
module lrupr_checker import lrupr_pkg::*; #(
  parameter int PAGE_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  hit,
  input logic                  evicted_valid,
  input logic [PAGE_BITS-1:0]  evicted_page
);

  // an accepted request holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a result only follows a busy period and frees the block
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe outside a request");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    done && evicted_valid |-> !hit)
    else $error("eviction reported on a hit");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (rst)
    done && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page nonzero without eviction");

endmodule

bind lru_page_replacement_top lrupr_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_lrupr_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page)
);

// ===== sim/tb_lru_page_replacement_top.sv =====
// Testbench for lru_page_replacement_top: drives page requests, predicts each
// result with an LRU scoreboard class and checks every done strobe against it.
// Depends on lrupr_pkg and the lru_page_replacement_top RTL.
`timescale 1ns / 1ps

module tb_lru_page_replacement_top;
  import lrupr_pkg::*;

  localparam int PAGE_W    = 16;
  localparam int SLOTS     = 16;
  localparam int DRAIN_CYC = 40;    // margin beyond the longest request
  localparam int WDOG_CYC  = 2000;  // cycles without any handshake

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted_valid;
    logic [PAGE_W-1:0]     evicted_page;
    logic [OCC_W-1:0]      occupied;
    logic [TOTAL_W-1:0]    fault_total;
    logic [TOTAL_W-1:0]    hit_total;
  } outcome_t;

  class lru_scoreboard;
    logic [PAGE_W-1:0]  frame_page [SLOTS];
    int unsigned        frame_rank [SLOTS];
    int unsigned        filled;
    logic [TOTAL_W-1:0] fault_cnt;
    logic [TOTAL_W-1:0] hit_cnt;
    logic [CFG_W-1:0]   frame_count;
    outcome_t           expected_q[$];
    int unsigned        failures;

    function new();
      frame_count = FRAME_COUNT_RESET;
      filled      = 0;
      fault_cnt   = '0;
      hit_cnt     = '0;
      failures    = 0;
    endfunction

    function void set_frame_count(logic [CFG_W-1:0] v);
      frame_count = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // slot s becomes most recent; filled slots ranked below lim age by one
    function void age_ranks(int unsigned s, int unsigned lim);
      for (int unsigned f = 0; f < filled; f++)
        if (f != s && frame_rank[f] < lim) frame_rank[f]++;
      frame_rank[s] = 0;
    endfunction

    function void note_reference(logic [PAGE_W-1:0] pg, logic restart);
      outcome_t    o;
      int unsigned cap;
      int unsigned oldest;
      bit          found;
      o      = '0;
      found  = 0;
      oldest = 0;
      cap    = (frame_count == 0) ? 1 : (frame_count > SLOTS) ? SLOTS : frame_count;
      if (restart) begin
        filled    = 0;
        fault_cnt = '0;
        hit_cnt   = '0;
      end
      for (int unsigned f = 0; f < filled; f++) begin
        if (!found && frame_page[f] == pg) begin
          found  = 1;
          o.slot = SLOT_OUT_W'(f);
        end
      end
      if (found) begin
        hit_cnt++;
        age_ranks(o.slot, frame_rank[o.slot]);
      end else begin
        fault_cnt++;
        if (filled >= cap) begin
          // filled may exceed cap after a lowered frame_count: search all
          for (int unsigned f = 0; f < filled; f++)
            if (frame_rank[f] >= frame_rank[oldest]) oldest = f;
          o.slot             = SLOT_OUT_W'(oldest);
          o.evicted_valid    = 1'b1;
          o.evicted_page     = frame_page[oldest];
          frame_page[oldest] = pg;
          age_ranks(oldest, frame_rank[oldest]);
        end else begin
          o.slot             = SLOT_OUT_W'(filled);
          frame_page[filled] = pg;
          frame_rank[filled] = filled;
          filled++;
          age_ranks(o.slot, 255);
        end
      end
      o.hit         = found;
      o.occupied    = OCC_W'(filled);
      o.fault_total = fault_cnt;
      o.hit_total   = hit_cnt;
      expected_q.push_back(o);
    endfunction

    function void compare_field(string name, logic [TOTAL_W-1:0] exp_v,
                                logic [TOTAL_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h",
                 $time, name, exp_v, act_v);
        failures++;
      end
    endfunction

    function void check_outcome(outcome_t act);
      outcome_t exp_o;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request outstanding: actual %p", $time, act);
        failures++;
        return;
      end
      exp_o = expected_q.pop_front();
      compare_field("hit",           exp_o.hit,           act.hit);
      compare_field("slot",          exp_o.slot,          act.slot);
      compare_field("evicted_valid", exp_o.evicted_valid, act.evicted_valid);
      compare_field("evicted_page",  exp_o.evicted_page,  act.evicted_page);
      compare_field("occupied",      exp_o.occupied,      act.occupied);
      compare_field("fault_total",   exp_o.fault_total,   act.fault_total);
      compare_field("hit_total",     exp_o.hit_total,     act.hit_total);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PAGE_W-1:0]     page = '0;
  logic                  start_string = 1'b0;
  logic                  done;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  evicted_valid;
  logic [PAGE_W-1:0]     evicted_page;
  logic [OCC_W-1:0]      occupied;
  logic [TOTAL_W-1:0]    fault_total;
  logic [TOTAL_W-1:0]    hit_total;

  lru_scoreboard sb = new();
  int unsigned   quiet_cycles = 0;

  lru_page_replacement_top #(
    .MAX_FRAME_SLOTS(SLOTS),
    .PAGE_BITS(PAGE_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .page(page),
    .start_string(start_string),
    .done(done),
    .hit(hit),
    .slot(slot),
    .evicted_valid(evicted_valid),
    .evicted_page(evicted_page),
    .occupied(occupied),
    .fault_total(fault_total),
    .hit_total(hit_total)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // results are checked before a request taken at the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_outcome('{hit, slot, evicted_valid, evicted_page, occupied,
                           fault_total, hit_total});
      if (start && !busy) sb.note_reference(page, start_string);
      if (cfg_we) sb.set_frame_count(cfg_data);
      if (done || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (quiet_cycles >= WDOG_CYC) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // holds start high until the request is taken, then maybe leaves a gap
  task automatic send_reference(logic [PAGE_W-1:0] pg, logic restart, int idle_pct);
    int gap;
    gap          = 0;
    start        <= 1'b1;
    page         <= pg;
    start_string <= restart;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [CFG_W-1:0] v);
    wait_results_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly a small working set near base so hits and evictions are frequent
  function automatic logic [PAGE_W-1:0] pick_page(logic [PAGE_W-1:0] base,
                                                   int unsigned pool);
    if ($urandom_range(99) < 15) return PAGE_W'($urandom);
    return PAGE_W'(base + $urandom_range(pool - 1));
  endfunction

  initial begin
    logic [CFG_W-1:0]  fc_list [6];
    int                idle_list [6];
    logic [PAGE_W-1:0] base;
    int unsigned       pool;
    fc_list   = '{5'd16, 5'd4, 5'd31, 5'd0, 5'd1, 5'd9};
    idle_list = '{0, 58, 0, 8, 58, 0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // three frames: fill, hit, then evict the least recent
    write_frame_count(5'd3);
    send_reference(16'h0000, 1'b1, 0);
    send_reference(16'hFFFF, 1'b0, 0);
    send_reference(16'h0000, 1'b0, 0);
    send_reference(16'h0005, 1'b0, 0);
    send_reference(16'h0007, 1'b0, 0);
    send_reference(16'h0000, 1'b0, 0);
    send_reference(16'h0009, 1'b0, 0);
    send_reference(16'h8000, 1'b0, 0);
    // capacity below filled count: replace among all three, occupied stays
    write_frame_count(5'd1);
    send_reference(16'h1234, 1'b0, 0);
    send_reference(16'h1234, 1'b0, 0);
    send_reference(16'h00FF, 1'b0, 0);
    // zero frames acts as one
    write_frame_count(5'd0);
    send_reference(16'hAAAA, 1'b1, 0);
    send_reference(16'h5555, 1'b0, 0);
    send_reference(16'h5555, 1'b0, 0);
    // oversize count saturates to sixteen
    write_frame_count(5'd31);
    send_reference(16'hAAAA, 1'b1, 0);
    send_reference(16'h5555, 1'b0, 0);
    send_reference(16'hAAAA, 1'b0, 0);
    send_reference(16'hFFFF, 1'b0, 0);

    for (int p = 0; p < 6; p++) begin
      write_frame_count(fc_list[p]);
      base = PAGE_W'($urandom);
      pool = ((fc_list[p] == 0) ? 1 : (fc_list[p] > SLOTS) ? SLOTS : fc_list[p])
             + $urandom_range(1, 5);
      for (int i = 0; i < 125; i++) begin
        send_reference(pick_page(base, pool), ($urandom_range(99) < 3), idle_list[p]);
        if ($urandom_range(99) < 2) wait_results_drained();
      end
    end

    wait_results_drained();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
